// ===== sv/dht_pkg.sv =====
// ----------------------------------------------------------------------------
// dht_pkg
// Types and constants shared by the dictionary header tokenizer modules.
// ----------------------------------------------------------------------------
package dht_pkg;

    localparam int CH_W      = 8;
    localparam int KIND_W    = 2;
    localparam int IDX_W     = 6;
    localparam int OPOS_W    = 16;
    localparam int CNT_W     = 7;
    localparam int NEST_W    = 8;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = 2;
    localparam int OUTQ_CW    = 3;

    localparam logic [CNT_W-1:0] MAX_TOK_RESET = 7'd10;

    localparam logic [KIND_W-1:0] KIND_KEY   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VALUE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

    localparam logic signed [NEST_W-1:0] NEST_MAX = 8'sd127;
    localparam logic signed [NEST_W-1:0] NEST_MIN = -8'sd127;

    localparam logic [CH_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CH_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CH_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CH_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_QUOTE  = 8'h27;

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_KEY_OPEN,
        PH_KEY_CLOSE,
        PH_COLON,
        PH_VAL_OPEN,
        PH_VAL_CLOSE,
        PH_STOPPED
    } phase_t;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  tok_index;
        logic [OPOS_W-1:0] tok_start;
        logic [OPOS_W-1:0] tok_end;
        logic [CNT_W-1:0]  tok_count;
        logic              final_res;
    } out_item_t;

    typedef struct packed {
        logic push0;
        logic push1;
    } push_t;

endpackage

// ===== sv/dht_core.sv =====
// ----------------------------------------------------------------------------
// dht_core
// Scan state and per-character update; emits up to two results per character.
// ----------------------------------------------------------------------------
module dht_core #(
    parameter int POS_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fire,
    input  dht_pkg::in_item_t             in_data,
    input  logic [dht_pkg::CNT_W-1:0]     max_tokens,
    output dht_pkg::push_t                push,
    output dht_pkg::out_item_t            res0,
    output dht_pkg::out_item_t            res1
);
    import dht_pkg::*;

    phase_t                   phase_reg, phase_next;
    logic [POS_BITS-1:0]      pos_reg, pos_next;
    logic [POS_BITS-1:0]      pend_reg, pend_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [NEST_W-1:0] nest_reg, nest_next;

    logic                     is_open, is_close, scanned, tok_emit, key_emit;
    logic [POS_BITS-1:0]      pos_inc;
    logic signed [NEST_W-1:0] nest_upd;
    logic [CNT_W-1:0]         cnt_upd;
    logic [POS_BITS+OPOS_W-1:0] start_ext, end_ext;
    out_item_t                tok_res, done_res;

    assign is_open  = in_data.ch inside {CH_LPAREN, CH_LBRACK, CH_LBRACE};
    assign is_close = in_data.ch inside {CH_RPAREN, CH_RBRACK, CH_RBRACE};
    assign pos_inc  = pos_reg + 1'b1;

    always_comb begin
        nest_upd = nest_reg;
        case (phase_reg)
            PH_VAL_OPEN: begin
                nest_upd = is_open ? NEST_W'(1) : '0;
            end
            PH_VAL_CLOSE: begin
                if (is_open && nest_reg != NEST_MAX) begin
                    nest_upd = nest_reg + 1'b1;
                end else if (is_close && nest_reg != NEST_MIN) begin
                    nest_upd = nest_reg - 1'b1;
                end
            end
            default: nest_upd = nest_reg;
        endcase
    end

    assign key_emit = (phase_reg == PH_KEY_CLOSE) && (in_data.ch == CH_QUOTE);
    assign tok_emit = key_emit ||
                      ((phase_reg == PH_VAL_CLOSE) && (nest_upd == '0) &&
                       (in_data.ch == CH_COMMA));
    assign scanned  = (phase_reg == PH_SEEK) ? (in_data.ch == CH_LBRACE)
                                              : (phase_reg != PH_STOPPED);
    assign cnt_upd  = cnt_reg + CNT_W'(tok_emit);

    // next state
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_SEEK:      if (in_data.ch == CH_LBRACE) phase_next = PH_KEY_OPEN;
            PH_KEY_OPEN:  if (in_data.ch == CH_QUOTE)  phase_next = PH_KEY_CLOSE;
            PH_KEY_CLOSE: if (in_data.ch == CH_QUOTE)  phase_next = PH_COLON;
            PH_COLON:     if (in_data.ch == CH_COLON)  phase_next = PH_VAL_OPEN;
            PH_VAL_OPEN:  if (in_data.ch != CH_SPACE)  phase_next = PH_VAL_CLOSE;
            PH_VAL_CLOSE: if (tok_emit)                phase_next = PH_KEY_OPEN;
            PH_STOPPED:   phase_next = PH_STOPPED;
            default:      phase_next = PH_SEEK;
        endcase
        if (scanned && cnt_upd >= max_tokens) begin
            phase_next = PH_STOPPED;
        end
        if (in_data.last) begin
            phase_next = PH_SEEK;
        end
    end

    always_comb begin
        pend_next = pend_reg;
        if ((phase_reg == PH_KEY_OPEN && in_data.ch == CH_QUOTE) ||
            (phase_reg == PH_VAL_OPEN && in_data.ch != CH_SPACE)) begin
            pend_next = pos_reg;
        end
        pos_next  = pos_inc;
        cnt_next  = cnt_upd;
        nest_next = nest_upd;
        if (in_data.last) begin
            pend_next = '0;
            pos_next  = '0;
            cnt_next  = '0;
            nest_next = '0;
        end
    end

    // outputs
    always_comb begin
        start_ext = {{OPOS_W{1'b0}}, pend_reg};
        end_ext   = {{OPOS_W{1'b0}}, (key_emit ? pos_inc : pos_reg)};

        tok_res.kind      = key_emit ? KIND_KEY : KIND_VALUE;
        tok_res.tok_index = cnt_reg[IDX_W-1:0];
        tok_res.tok_start = start_ext[OPOS_W-1:0];
        tok_res.tok_end   = end_ext[OPOS_W-1:0];
        tok_res.tok_count = '0;
        tok_res.final_res = 1'b0;

        done_res.kind      = KIND_DONE;
        done_res.tok_index = '0;
        done_res.tok_start = '0;
        done_res.tok_end   = '0;
        done_res.tok_count = cnt_upd;
        done_res.final_res = 1'b1;

        res0       = tok_emit ? tok_res : done_res;
        res1       = done_res;
        push.push0 = fire && (tok_emit || in_data.last);
        push.push1 = fire && tok_emit && in_data.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SEEK;
            pos_reg   <= '0;
            pend_reg  <= '0;
            cnt_reg   <= '0;
            nest_reg  <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            nest_reg  <= nest_next;
        end
    end

endmodule

// ===== sv/dht_outq.sv =====
// ----------------------------------------------------------------------------
// dht_outq
// Small result queue: takes up to two results a cycle, hands out one while m_ready is high.
// ----------------------------------------------------------------------------
module dht_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  dht_pkg::push_t      push,
    input  dht_pkg::out_item_t  res0,
    input  dht_pkg::out_item_t  res1,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output dht_pkg::out_item_t  m_data
);
    import dht_pkg::*;

    out_item_t            mem_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [OUTQ_AW-1:0]   wr_ptr_inc;
    logic [OUTQ_CW-1:0]   count_reg, count_next;
    logic                 pop;

    assign m_valid    = (count_reg != '0);
    assign m_data     = mem_reg[rd_ptr_reg];
    assign pop        = m_valid && m_ready;
    assign room       = (count_reg <= OUTQ_CW'(OUTQ_DEPTH - 2));
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;
    assign count_next = count_reg + OUTQ_CW'(push.push0) + OUTQ_CW'(push.push1)
                        - OUTQ_CW'(pop);

    always_ff @(posedge aclk) begin
        if (push.push0) begin
            mem_reg[wr_ptr_reg] <= res0;
        end
        if (push.push1) begin
            mem_reg[wr_ptr_inc] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push.push1) begin
                wr_ptr_reg <= wr_ptr_reg + OUTQ_AW'(2);
            end else if (push.push0) begin
                wr_ptr_reg <= wr_ptr_inc;
            end
        end
    end

endmodule

// ===== sv/dict_header_tokenizer.sv =====
// ----------------------------------------------------------------------------
// dict_header_tokenizer
// Splits a flat key:value dictionary header into key and value tokens.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one header character per transaction, with
//   last set on the final character of a header. m_valid/m_ready/m_data carry
//   results: key and value tokens with their start and end positions, and a
//   done result with the token count after the final character.
//   cfg_valid/cfg_ready/cfg_data write max_tokens; write it only while idle.
//   A character is scanned while it sits in the input register; its results
//   enter the queue at the edge on which it leaves that register, so m_valid
//   rises only after both the input register and the queue have taken it.
//   One character is accepted per cycle while the queue has room; one that
//   yields a token and a done result fills two of the four queue slots.
//   The input register advances only while the queue has two free slots, so
//   a stalled receiver stops input once three results are waiting; characters
//   that yield no result keep flowing until then.
//   Reset clears the scan state and the queue and sets max_tokens to 10.
// ----------------------------------------------------------------------------
module dict_header_tokenizer #(
    parameter int POS_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  dht_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output dht_pkg::out_item_t          m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dht_pkg::CNT_W-1:0]   cfg_data
);
    import dht_pkg::*;

    logic              in_valid_reg;
    in_item_t          in_data_reg;
    logic [CNT_W-1:0]  max_tok_reg;
    logic              fire, room;
    push_t             push;
    out_item_t         res0, res1;

    assign fire      = in_valid_reg && room;
    assign s_ready   = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            max_tok_reg  <= MAX_TOK_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (cfg_valid) begin
                max_tok_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    dht_core #(
        .POS_BITS (POS_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .in_data    (in_data_reg),
        .max_tokens (max_tok_reg),
        .push       (push),
        .res0       (res0),
        .res1       (res1)
    );

    dht_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .res0    (res0),
        .res1    (res1),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== dv/dht_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_checker
// Watches the character, result and register channels of the dictionary
// header tokenizer, keeps its own copy of the scan state and compares every
// result transaction, field by field, with the oldest predicted token.
// ----------------------------------------------------------------------------
module dht_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  dht_pkg::in_item_t           s_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  dht_pkg::out_item_t          m_data,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [dht_pkg::CNT_W-1:0]   cfg_data,
    output int                          n_pending,
    output int                          n_fail
);
    import dht_pkg::*;

    phase_t            ph;
    logic [15:0]       pos;
    logic [15:0]       tok_begin;
    logic [CNT_W-1:0]  ntok;
    logic [CNT_W-1:0]  tok_limit;
    int                depth;
    int                shown;
    out_item_t         tokens_due[$];

    initial begin
        n_fail    = 0;
        n_pending = 0;
        shown     = 0;
    end

    function automatic bit opens(logic [7:0] c);
        return c == CH_LPAREN || c == CH_LBRACK || c == CH_LBRACE;
    endfunction

    function automatic bit closes(logic [7:0] c);
        return c == CH_RPAREN || c == CH_RBRACK || c == CH_RBRACE;
    endfunction

    function automatic int clamp_depth(int d);
        if (d > int'(NEST_MAX)) return int'(NEST_MAX);
        if (d < int'(NEST_MIN)) return int'(NEST_MIN);
        return d;
    endfunction

    task automatic report(string what, longint want, longint got);
        n_fail++;
        if (shown < 40) begin
            $display("[%0t] mismatch on %s: expected %0d, got %0d",
                     $realtime, what, want, got);
        end
        shown++;
    endtask

    task automatic clear_scan();
        ph        = PH_SEEK;
        pos       = '0;
        ntok      = '0;
        depth     = 0;
        tok_begin = '0;
    endtask

    task automatic log_token(logic [KIND_W-1:0] k, logic [15:0] first, logic [15:0] past);
        out_item_t r;
        r           = '0;
        r.kind      = k;
        r.tok_index = ntok[IDX_W-1:0];
        r.tok_start = first;
        r.tok_end   = past;
        tokens_due.push_back(r);
        ntok = ntok + 1'b1;
    endtask

    task automatic scan_char(in_item_t it);
        logic [7:0]  c;
        logic [15:0] here;
        bit          scanned;
        out_item_t   fin;
        c       = it.ch;
        here    = pos;
        scanned = 1'b0;
        if (ph == PH_SEEK) begin
            if (c == CH_LBRACE) begin
                ph      = PH_KEY_OPEN;
                scanned = 1'b1;
            end
        end else if (ph != PH_STOPPED) begin
            scanned = 1'b1;
            case (ph)
                PH_KEY_OPEN: begin
                    if (c == CH_QUOTE) begin
                        ph        = PH_KEY_CLOSE;
                        tok_begin = here;
                    end
                end
                PH_KEY_CLOSE: begin
                    if (c == CH_QUOTE) begin
                        log_token(KIND_KEY, tok_begin, here + 16'd1);
                        ph = PH_COLON;
                    end
                end
                PH_COLON: begin
                    if (c == CH_COLON) ph = PH_VAL_OPEN;
                end
                PH_VAL_OPEN: begin
                    depth = 0;
                    if (c != CH_SPACE) begin
                        if (opens(c)) depth = 1;
                        ph        = PH_VAL_CLOSE;
                        tok_begin = here;
                    end
                end
                default: begin
                    if (opens(c)) depth = clamp_depth(depth + 1);
                    else if (closes(c)) depth = clamp_depth(depth - 1);
                    if (depth == 0 && c == CH_COMMA) begin
                        log_token(KIND_VALUE, tok_begin, here);
                        ph = PH_KEY_OPEN;
                    end
                end
            endcase
        end
        pos = here + 16'd1;
        if (scanned && ntok >= tok_limit) ph = PH_STOPPED;
        if (it.last) begin
            fin           = '0;
            fin.kind      = KIND_DONE;
            fin.tok_count = ntok;
            fin.final_res = 1'b1;
            tokens_due.push_back(fin);
            clear_scan();
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            clear_scan();
            tok_limit = MAX_TOK_RESET;
            tokens_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) tok_limit = cfg_data;
            if (s_valid && s_ready) scan_char(s_data);
            if (m_valid && m_ready) begin
                if (tokens_due.size() == 0) begin
                    report("unexpected result, kind", -1, m_data.kind);
                end else begin
                    want = tokens_due.pop_front();
                    if (m_data.kind !== want.kind)
                        report("kind", want.kind, m_data.kind);
                    if (m_data.tok_index !== want.tok_index)
                        report("tok_index", want.tok_index, m_data.tok_index);
                    if (m_data.tok_start !== want.tok_start)
                        report("tok_start", want.tok_start, m_data.tok_start);
                    if (m_data.tok_end !== want.tok_end)
                        report("tok_end", want.tok_end, m_data.tok_end);
                    if (m_data.tok_count !== want.tok_count)
                        report("tok_count", want.tok_count, m_data.tok_count);
                    if (m_data.final_res !== want.final_res)
                        report("final_res", want.final_res, m_data.final_res);
                end
            end
        end
        n_pending = tokens_due.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives header strings into the dictionary header tokenizer: a few fixed
// headers, then random well-formed, truncated and noisy headers under several
// max_tokens settings, and two headers that push the bracket depth into
// saturation. Both channels idle at random and the result side holds off for
// long stretches. dht_checker does the checking.
// ----------------------------------------------------------------------------
module tb_top;
    import dht_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_CHARS = 55;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    int         n_pending;
    int         n_fail;
    int         cycles = 0;
    bit         idle_on = 1'b1;
    int         hold_req = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         stall_left = 0;
    int         sent = 0;
    int         cur_max;
    logic [7:0] hdr_q[$];
    logic [7:0] marks[10];
    int         tok_plan[8];

    dict_header_tokenizer #(.POS_BITS(16)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    dht_checker chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .n_pending (n_pending),
        .n_fail    (n_fail)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) @(posedge aclk) cycles++;
        $display("tb_top failed");
        $finish;
    end

    function automatic int gap_len();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // result side: random stalls plus long hold-offs on request
    initial begin
        m_ready = 1'b0;
        forever @(negedge aclk) begin
            if (hold_left == 0 && hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = gap_len();
            end
        end
    end

    function automatic bit is_bracket(logic [7:0] b);
        return b == CH_LPAREN || b == CH_LBRACK || b == CH_LBRACE ||
               b == CH_RPAREN || b == CH_RBRACK || b == CH_RBRACE;
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_LBRACE);
        return b;
    endfunction

    function automatic logic [7:0] key_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
        return b;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (is_bracket(b) || b == CH_COMMA);
        return b;
    endfunction

    function automatic logic [7:0] open_byte();
        case ($urandom_range(0, 2))
            0: return CH_LPAREN;
            1: return CH_LBRACK;
            default: return CH_LBRACE;
        endcase
    endfunction

    function automatic logic [7:0] close_byte();
        case ($urandom_range(0, 2))
            0: return CH_RPAREN;
            1: return CH_RBRACK;
            default: return CH_RBRACE;
        endcase
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) hdr_q.push_back(s[i]);
    endtask

    task automatic add_run(logic [7:0] b, int n);
        repeat (n) hdr_q.push_back(b);
    endtask

    task automatic add_spaces();
        add_run(CH_SPACE, $urandom_range(0, 2));
    endtask

    task automatic add_value();
        int r;
        int k;
        r = $urandom_range(0, 199);
        if (r < 90) begin
            repeat ($urandom_range(1, 5)) hdr_q.push_back(plain_byte());
        end else if (r < 150) begin
            hdr_q.push_back(open_byte());
            repeat ($urandom_range(0, 6)) begin
                case ($urandom_range(0, 3))
                    0: hdr_q.push_back(plain_byte());
                    1: hdr_q.push_back(CH_COMMA);
                    2: hdr_q.push_back(CH_SPACE);
                    default: begin
                        hdr_q.push_back(open_byte());
                        hdr_q.push_back(plain_byte());
                        hdr_q.push_back(close_byte());
                    end
                endcase
            end
            hdr_q.push_back(close_byte());
        end else if (r < 170) begin
            hdr_q.push_back(open_byte());
            hdr_q.push_back(plain_byte());
        end else if (r < 197) begin
            hdr_q.push_back(plain_byte());
            hdr_q.push_back(close_byte());
        end else if (r < 199) begin
            k = $urandom_range(126, 140);
            add_run(CH_LBRACK, k);
            add_run(CH_RBRACK, $urandom_range(120, k));
        end else begin
            hdr_q.push_back(plain_byte());
            add_run(CH_RPAREN, $urandom_range(126, 140));
            add_run(CH_LPAREN, 127);
        end
    endtask

    // pairs < 0: random pair count, with noise and truncated headers mixed in
    task automatic build_header(int pairs);
        int npairs;
        int cut;
        hdr_q.delete();
        if (pairs < 0 && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) begin
                if ($urandom_range(0, 1)) hdr_q.push_back(marks[$urandom_range(0, 9)]);
                else hdr_q.push_back(8'($urandom_range(0, 255)));
            end
            return;
        end
        repeat ($urandom_range(0, 3)) hdr_q.push_back(junk_byte());
        hdr_q.push_back(CH_LBRACE);
        if (pairs >= 0) npairs = pairs;
        else if ($urandom_range(0, 4) == 0) npairs = $urandom_range(0, cur_max / 2 + 2);
        else npairs = $urandom_range(0, 5);
        repeat (npairs) begin
            add_spaces();
            hdr_q.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 4)) hdr_q.push_back(key_byte());
            hdr_q.push_back(CH_QUOTE);
            add_spaces();
            hdr_q.push_back(CH_COLON);
            add_spaces();
            add_value();
            hdr_q.push_back(CH_COMMA);
        end
        if ($urandom_range(0, 1)) hdr_q.push_back(CH_RBRACE);
        if (pairs < 0 && $urandom_range(0, 6) == 0) begin
            cut = $urandom_range(1, hdr_q.size());
            while (hdr_q.size() > cut) void'(hdr_q.pop_back());
        end
    endtask

    task automatic push_char(logic [7:0] c, logic fin);
        int gap;
        in_item_t item;
        gap       = gap_len();
        item.ch   = c;
        item.last = fin;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic send_header();
        foreach (hdr_q[i]) push_char(hdr_q[i], i == hdr_q.size() - 1);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (n_pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_max_tokens(int v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v[CNT_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_max = v;
    endtask

    initial begin
        int  start;
        bit  paused;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        cur_max   = MAX_TOK_RESET;
        marks     = '{CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_LBRACK,
                      CH_RBRACK, CH_COLON, CH_COMMA, CH_SPACE, CH_QUOTE};
        tok_plan  = '{10, 1, 64, 0, 127, 3, 0, 0};
        tok_plan[6] = $urandom_range(1, 64);
        tok_plan[7] = $urandom_range(2, 20);
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // fixed headers at the reset value of max_tokens
        hdr_q = '{8'h00, 8'hFF};
        add_text("{'':[),}");
        send_header();
        hdr_q.delete();
        add_text("{'a'");
        send_header();
        hdr_q.delete();
        add_text("{'ab");
        send_header();
        hdr_q.delete();
        add_text("{'k':v,");
        send_header();

        foreach (tok_plan[p]) begin
            drain();
            write_max_tokens(tok_plan[p]);
            idle_on = (p != 2);
            if (p == 0 || p == 4) hold_req++;
            start  = sent;
            paused = 1'b0;
            while (sent - start < PHASE_CHARS) begin
                if (p == 3 && !paused && sent - start > PHASE_CHARS / 2) begin
                    drain();
                    paused = 1'b1;
                end
                build_header(-1);
                send_header();
            end
        end

        // depth saturation both ways, token limit at 64
        drain();
        write_max_tokens(64);
        hdr_q.delete();
        add_text("{'a':");
        add_run(CH_LBRACK, 140);
        add_run(CH_RBRACK, 127);
        add_text(",}");
        send_header();
        hdr_q.delete();
        add_text("{'a':x");
        add_run(CH_RPAREN, 140);
        add_run(CH_LPAREN, 127);
        add_text(",}");
        send_header();
        build_header(34);
        send_header();

        drain();
        repeat (20) @(negedge aclk);
        if (n_fail == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== dict_header_tokenizer.f =====
sv/dht_pkg.sv
sv/dht_core.sv
sv/dht_outq.sv
sv/dict_header_tokenizer.sv
dv/dht_checker.sv
dv/tb_top.sv
